FILE: sv/rsp_packet_envelope_encoder_assert.svh
// Assertion macros for the packet envelope encoder.
`ifndef RSP_PACKET_ENVELOPE_ENCODER_ASSERT_SVH
`define RSP_PACKET_ENVELOPE_ENCODER_ASSERT_SVH

// Clocked assertion with explicit clock, disabled while reset is high.
`define RPE_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the default clock and reset names.
`define RPE_ASSERT(lbl, prop, msg) \
   `RPE_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

FILE: sv/rpe_pkg.sv
package rpe_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_STAR   = 8'h2a;
   localparam logic [7:0] CHAR_BRACE  = 8'h7d;
   localparam logic [7:0] CHAR_ETX    = 8'h03;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] HEX_ALPHA   = 8'h57;
   localparam logic [7:0] MAX_PLAIN   = 8'd126;
   localparam logic [7:0] ESC_XOR     = 8'h20;

   // Output steps of one item, emitted lowest bit first.
   localparam int STEP_DOLLAR = 0;
   localparam int STEP_ESC    = 1;
   localparam int STEP_DATA   = 2;
   localparam int STEP_HASH   = 3;
   localparam int STEP_HI     = 4;
   localparam int STEP_LO     = 5;
   localparam int NUM_STEPS   = 6;

   typedef logic [NUM_STEPS-1:0] step_mask_type;

   typedef struct packed {
      logic       dollar;
      logic       esc;
      logic       data;
      logic       trailer;
      logic [7:0] value;
   } job_type;

   function automatic logic [7:0] hex_lower(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + wide;
      end else begin
         return HEX_ALPHA + wide;
      end
   endfunction

endpackage

FILE: sv/rpe_req_if.sv
interface rpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       frame_start;
   logic       frame_end;
   logic       empty_frame;

   modport source (output valid, output payload_byte, output frame_start,
                   output frame_end, output empty_frame, input ready);
   modport sink   (input valid, input payload_byte, input frame_start,
                   input frame_end, input empty_frame, output ready);
endinterface

FILE: sv/rpe_rsp_if.sv
interface rpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       packet_done;
   logic       run_last;

   modport source (output valid, output out_byte, output packet_done,
                   output run_last, input ready);
   modport sink   (input valid, input out_byte, input packet_done,
                   input run_last, output ready);
endinterface

FILE: sv/rpe_front.sv
module rpe_front (
   input  logic            clock,
   input  logic            reset,
   rpe_req_if.sink         req_ch,
   input  logic            q_full,
   output logic            q_push,
   output rpe_pkg::job_type q_job
);

   logic [7:0] prev_raw_ff;
   logic [7:0] prev_raw_in;
   logic [7:0] prev_eff;
   logic [7:0] c;
   logic       special;
   logic       escape;

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;
   assign c            = req_ch.payload_byte;

   always_comb begin
      prev_eff = req_ch.frame_start ? 8'h00 : prev_raw_ff;
      special  = (c == rpe_pkg::CHAR_DOLLAR) || (c == rpe_pkg::CHAR_HASH) ||
                 (c == rpe_pkg::CHAR_STAR) || (c == rpe_pkg::CHAR_BRACE) ||
                 (c == rpe_pkg::CHAR_ETX);
      escape   = (special && (prev_eff != rpe_pkg::CHAR_STAR)) || (c > rpe_pkg::MAX_PLAIN);
   end

   always_comb begin
      if (req_ch.empty_frame) begin
         q_job.dollar  = 1'b1;
         q_job.esc     = 1'b0;
         q_job.data    = 1'b0;
         q_job.trailer = 1'b1;
         q_job.value   = 8'h00;
      end else begin
         q_job.dollar  = req_ch.frame_start;
         q_job.esc     = escape;
         q_job.data    = 1'b1;
         q_job.trailer = req_ch.frame_end;
         q_job.value   = escape ? (c ^ rpe_pkg::ESC_XOR) : c;
      end
   end

   always_comb begin
      prev_raw_in = prev_raw_ff;
      if (q_push) begin
         prev_raw_in = req_ch.empty_frame ? 8'h00 : c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= 8'h00;
      end else begin
         prev_raw_ff <= prev_raw_in;
      end
   end

endmodule

FILE: sv/rpe_queue.sv
module rpe_queue #(
   parameter int Depth = rpe_pkg::QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rpe_pkg::job_type push_data,
   output logic            full,
   input  logic            pop,
   output rpe_pkg::job_type pop_data,
   output logic            empty
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

   rpe_pkg::job_type mem_ff [Depth];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/rpe_back.sv
module rpe_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  rpe_pkg::job_type q_job,
   output logic            q_pop,
   rpe_rsp_if.source       rsp_ch
);

   rpe_pkg::step_mask_type mask_ff, mask_in;
   rpe_pkg::step_mask_type sel;
   rpe_pkg::step_mask_type load_mask;
   logic [7:0] value_ff, value_in;
   logic [7:0] sum_ff, sum_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       done_ff, done_in;
   logic       last_ff, last_in;
   logic       advance;
   logic       emit;
   logic       single;
   logic       can_load;

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.packet_done = done_ff;
   assign rsp_ch.run_last    = last_ff;

   assign advance  = !valid_ff || rsp_ch.ready;
   assign emit     = advance && (mask_ff != '0);
   assign sel      = mask_ff & (~mask_ff + rpe_pkg::NUM_STEPS'(1));
   assign single   = (mask_ff & (mask_ff - rpe_pkg::NUM_STEPS'(1))) == '0;
   assign can_load = (mask_ff == '0) || (emit && single);
   assign q_pop    = can_load && !q_empty;

   always_comb begin
      load_mask = '0;
      load_mask[rpe_pkg::STEP_DOLLAR] = q_job.dollar;
      load_mask[rpe_pkg::STEP_ESC]    = q_job.esc;
      load_mask[rpe_pkg::STEP_DATA]   = q_job.data;
      load_mask[rpe_pkg::STEP_HASH]   = q_job.trailer;
      load_mask[rpe_pkg::STEP_HI]     = q_job.trailer;
      load_mask[rpe_pkg::STEP_LO]     = q_job.trailer;
   end

   always_comb begin
      byte_in = byte_ff;
      done_in = done_ff;
      last_in = last_ff;
      sum_in  = sum_ff;
      if (emit) begin
         done_in = sel[rpe_pkg::STEP_LO];
         last_in = single;
         if (sel[rpe_pkg::STEP_DOLLAR]) begin
            byte_in = rpe_pkg::CHAR_DOLLAR;
            sum_in  = 8'h00;
         end else if (sel[rpe_pkg::STEP_ESC]) begin
            byte_in = rpe_pkg::CHAR_BRACE;
            sum_in  = sum_ff + rpe_pkg::CHAR_BRACE;
         end else if (sel[rpe_pkg::STEP_DATA]) begin
            byte_in = value_ff;
            sum_in  = sum_ff + value_ff;
         end else if (sel[rpe_pkg::STEP_HASH]) begin
            byte_in = rpe_pkg::CHAR_HASH;
         end else if (sel[rpe_pkg::STEP_HI]) begin
            byte_in = rpe_pkg::hex_lower(sum_ff[7:4]);
         end else begin
            byte_in = rpe_pkg::hex_lower(sum_ff[3:0]);
         end
      end
   end

   always_comb begin
      valid_in = advance ? emit : valid_ff;
      value_in = q_pop ? q_job.value : value_ff;
      if (q_pop) begin
         mask_in = load_mask;
      end else if (emit) begin
         mask_in = mask_ff & ~sel;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
         sum_ff   <= 8'h00;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      byte_ff  <= byte_in;
      done_ff  <= done_in;
      last_ff  <= last_in;
   end

endmodule

FILE: sv/rsp_packet_envelope_encoder.sv
// Packet envelope encoder. Each req transfer carries one payload byte (or an empty
// frame) and yields one to six rsp bytes: an optional '$', the byte or its
// two-byte escape, and, on frame end, '#' plus two lowercase hex checksum digits.
// The front end escapes and classifies each byte in the cycle it is taken and writes
// a descriptor into a QueueDepth-entry queue; it takes one req transfer per cycle
// while the queue has room. The back end expands descriptors at one rsp byte per
// clock while the rsp side accepts bytes; a plain mid-frame byte yields one rsp byte,
// an escaped one two, a one-byte frame up to six. On an idle block the first rsp
// byte of an item passes through the queue, the step mask and the output register.
module rsp_packet_envelope_encoder #(
   parameter int QueueDepth = rpe_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   rpe_req_if.sink   req_ch,
   rpe_rsp_if.source rsp_ch
);

   rpe_pkg::job_type push_job;
   rpe_pkg::job_type head_job;
   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;

   rpe_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job)
   );

   rpe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_job),
      .empty     (q_empty)
   );

   rpe_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_job   (head_job),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

FILE: sv/rpe_checker.sv
`include "rsp_packet_envelope_encoder_assert.svh"

module rpe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_packet_done,
   input logic       rsp_run_last
);

   logic is_hex_digit;

   assign is_hex_digit = ((rsp_out_byte >= rpe_pkg::CHAR_ZERO) && (rsp_out_byte <= 8'h39)) ||
                         ((rsp_out_byte >= 8'h61) && (rsp_out_byte <= 8'h66));

   `RPE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped while stalled")
   `RPE_ASSERT(a_done_last, rsp_valid && rsp_packet_done |-> rsp_run_last, "packet not item end")
   `RPE_ASSERT(a_done_hex, rsp_valid && rsp_packet_done |-> is_hex_digit, "final byte not hex")
   `RPE_ASSERT(a_reset_idle, $past(reset) |-> !rsp_valid, "rsp valid right after reset")

endmodule

bind rsp_packet_envelope_encoder rpe_checker u_rpe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_packet_done (rsp_ch.packet_done),
   .rsp_run_last    (rsp_ch.run_last)
);

FILE: tb/rsp_packet_envelope_encoder_tb.sv
`timescale 1ns / 1ps

module rsp_packet_envelope_encoder_tb;

   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam int         WATCHDOG_MAX  = 4000;
   localparam int         DRAIN_CYCLES  = 20;
   localparam int         PHASE_ITEMS   = 152;

   typedef struct packed {
      logic [7:0]      payload_byte;
      logic            sof;
      logic            eof;
      logic            empty;
      logic [2:0]      golden_n;
      logic [0:5][7:0] golden;
   } frame_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_done;
      logic       run_last;
   } env_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpe_req_if req_ch();
   rpe_rsp_if rsp_ch();

   rsp_packet_envelope_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   int             fail_count   = 0;
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;
   int             stall_cycles = 0;
   logic [7:0]     prev_raw     = '0;
   logic [7:0]     chk_sum      = '0;
   env_byte_type   step_out[$];
   env_byte_type   envelope_q[$];
   frame_item_type sent_q[$];
   frame_item_type directed_rows[$];

   // Envelope predictor

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return rpe_pkg::CHAR_ZERO + {4'h0, nib};
      end else begin
         return CHAR_LOWER_A + {4'h0, nib} - 8'd10;
      end
   endfunction

   function automatic void emit(input logic [7:0] b, input logic done);
      env_byte_type e;
      e.out_byte    = b;
      e.packet_done = done;
      e.run_last    = 1'b0;
      step_out.push_back(e);
   endfunction

   function automatic void emit_payload(input logic [7:0] b);
      chk_sum = chk_sum + b;
      emit(b, 1'b0);
   endfunction

   function automatic void envelope(input logic [7:0] b, input logic sof, input logic eof,
                                    input logic empty);
      logic special;
      step_out.delete();
      if (empty) begin
         prev_raw = '0;
         chk_sum  = '0;
         emit(rpe_pkg::CHAR_DOLLAR, 1'b0);
         emit(rpe_pkg::CHAR_HASH, 1'b0);
         emit(rpe_pkg::CHAR_ZERO, 1'b0);
         emit(rpe_pkg::CHAR_ZERO, 1'b1);
      end else begin
         if (sof) begin
            prev_raw = '0;
            chk_sum  = '0;
            emit(rpe_pkg::CHAR_DOLLAR, 1'b0);
         end
         special = (b == rpe_pkg::CHAR_DOLLAR) || (b == rpe_pkg::CHAR_HASH) ||
                   (b == rpe_pkg::CHAR_STAR) || (b == rpe_pkg::CHAR_BRACE) ||
                   (b == rpe_pkg::CHAR_ETX);
         if ((special && prev_raw != rpe_pkg::CHAR_STAR) || b > rpe_pkg::MAX_PLAIN) begin
            emit_payload(rpe_pkg::CHAR_BRACE);
            emit_payload(b ^ rpe_pkg::ESC_XOR);
         end else begin
            emit_payload(b);
         end
         prev_raw = b;
         if (eof) begin
            emit(rpe_pkg::CHAR_HASH, 1'b0);
            emit(hex_digit(chk_sum[7:4]), 1'b0);
            emit(hex_digit(chk_sum[3:0]), 1'b1);
         end
      end
      step_out[step_out.size()-1].run_last = 1'b1;
   endfunction

   // Req monitor: every accepted transfer is predicted; directed rows with
   // a typed-in answer use that instead of the predictor output.
   always @(posedge clock) begin : req_monitor
      frame_item_type it;
      env_byte_type   e;
      if (!reset && req_ch.valid && req_ch.ready) begin
         it = sent_q.pop_front();
         envelope(req_ch.payload_byte, req_ch.frame_start, req_ch.frame_end,
                  req_ch.empty_frame);
         if (it.golden_n != 0) begin
            for (int k = 0; k < it.golden_n; k++) begin
               e.out_byte    = it.golden[k];
               e.run_last    = (k == it.golden_n - 1);
               e.packet_done = e.run_last && (it.eof || it.empty);
               envelope_q.push_back(e);
            end
         end else begin
            foreach (step_out[k]) envelope_q.push_back(step_out[k]);
         end
      end
   end

   // Rsp side: random backpressure and checking
   always @(posedge clock) begin : rsp_check
      env_byte_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (envelope_q.size() == 0) begin
               $error("unexpected transfer: out_byte %h", rsp_ch.out_byte);
               fail_count++;
            end else begin
               e = envelope_q.pop_front();
               if (rsp_ch.out_byte !== e.out_byte) begin
                  $error("out_byte: expected %h, actual %h", e.out_byte, rsp_ch.out_byte);
                  fail_count++;
               end
               if (rsp_ch.packet_done !== e.packet_done) begin
                  $error("packet_done: expected %b, actual %b", e.packet_done,
                         rsp_ch.packet_done);
                  fail_count++;
               end
               if (rsp_ch.run_last !== e.run_last) begin
                  $error("run_last: expected %b, actual %b", e.run_last, rsp_ch.run_last);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus

   function automatic frame_item_type row(input logic [7:0] b, input logic sof,
                                          input logic eof, input logic empty,
                                          input int n, input logic [0:5][7:0] golden);
      frame_item_type it;
      it.payload_byte = b;
      it.sof          = sof;
      it.eof          = eof;
      it.empty        = empty;
      it.golden_n     = n[2:0];
      it.golden       = golden;
      return it;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return rpe_pkg::CHAR_DOLLAR;
         1: return rpe_pkg::CHAR_HASH;
         2, 3: return rpe_pkg::CHAR_STAR;
         4: return rpe_pkg::CHAR_BRACE;
         5: return rpe_pkg::CHAR_ETX;
         6: return 8'($urandom_range(127, 255));
         7: return 8'($urandom_range(120, 130));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send(input frame_item_type it);
      sent_q.push_back(it);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.payload_byte <= it.payload_byte;
      req_ch.frame_start  <= it.sof;
      req_ch.frame_end    <= it.eof;
      req_ch.empty_frame  <= it.empty;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin : stimulus
      int             count;
      int             len;
      logic           drop_sof;
      logic           drop_eof;
      frame_item_type it;

      req_ch.valid        = 1'b0;
      req_ch.payload_byte = '0;
      req_ch.frame_start  = 1'b0;
      req_ch.frame_end    = 1'b0;
      req_ch.empty_frame  = 1'b0;

      // Typed-in answers: empty frame, one-byte frames at the byte extremes
      // and the escape rules, empty frame with every other field set.
      directed_rows.push_back(row(8'h00, 1'b0, 1'b0, 1'b1, 4,
                                  {8'h24, 8'h23, 8'h30, 8'h30, 16'h0}));
      directed_rows.push_back(row(8'h00, 1'b1, 1'b1, 1'b0, 5,
                                  {8'h24, 8'h00, 8'h23, 8'h30, 8'h30, 8'h0}));
      directed_rows.push_back(row(8'hff, 1'b1, 1'b1, 1'b0, 6,
                                  {8'h24, 8'h7d, 8'hdf, 8'h23, 8'h35, 8'h63}));
      directed_rows.push_back(row(8'h7e, 1'b1, 1'b1, 1'b0, 5,
                                  {8'h24, 8'h7e, 8'h23, 8'h37, 8'h65, 8'h0}));
      directed_rows.push_back(row(8'h7f, 1'b1, 1'b1, 1'b0, 6,
                                  {8'h24, 8'h7d, 8'h5f, 8'h23, 8'h64, 8'h63}));
      directed_rows.push_back(row(8'h2a, 1'b1, 1'b1, 1'b0, 6,
                                  {8'h24, 8'h7d, 8'h0a, 8'h23, 8'h38, 8'h37}));
      directed_rows.push_back(row(8'h03, 1'b1, 1'b1, 1'b0, 6,
                                  {8'h24, 8'h7d, 8'h23, 8'h23, 8'h61, 8'h30}));
      directed_rows.push_back(row(8'hff, 1'b1, 1'b1, 1'b1, 4,
                                  {8'h24, 8'h23, 8'h30, 8'h30, 16'h0}));
      // Multi-byte frame through the specials, with the star-suppressed escapes
      directed_rows.push_back(row(rpe_pkg::CHAR_DOLLAR, 1'b1, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_HASH,   1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_STAR,   1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_STAR,   1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_BRACE,  1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_ETX,    1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_STAR,   1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_DOLLAR, 1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_STAR,   1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(8'h80,                1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(8'h41,                1'b0, 1'b1, 1'b0, 0, '0));
      // Bytes with no frame start keep the old state
      directed_rows.push_back(row(rpe_pkg::CHAR_BRACE,  1'b0, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(8'hfe,                1'b0, 1'b1, 1'b0, 0, '0));
      // Restart in the middle of a frame
      directed_rows.push_back(row(rpe_pkg::CHAR_STAR,   1'b1, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(rpe_pkg::CHAR_STAR,   1'b1, 1'b0, 1'b0, 0, '0));
      directed_rows.push_back(row(8'h01,                1'b0, 1'b1, 1'b0, 0, '0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send(directed_rows[i]);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 22; rsp_idle_pct = 84; end
            1: begin req_idle_pct = 84; rsp_idle_pct = 22; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0: begin
                  it = row(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 0, '0);
                  send(it);
                  count++;
               end
               1: begin
                  it = row(8'($urandom), 1'($urandom), 1'($urandom), 1'b1, 0, '0);
                  send(it);
                  count++;
               end
               default: begin
                  len      = $urandom_range(1, 6);
                  drop_sof = ($urandom_range(0, 9) == 0);
                  drop_eof = ($urandom_range(0, 9) == 0);
                  for (int k = 0; k < len; k++) begin
                     it = row(pick_byte(), (k == 0) && !drop_sof,
                              (k == len - 1) && !drop_eof, 1'b0, 0, '0);
                     send(it);
                     count++;
                  end
               end
            endcase
         end
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (envelope_q.size() != 0 || sent_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/rpe_pkg.sv
sv/rpe_req_if.sv
sv/rpe_rsp_if.sv
sv/rpe_front.sv
sv/rpe_queue.sv
sv/rpe_back.sv
sv/rsp_packet_envelope_encoder.sv
sv/rpe_checker.sv
tb/rsp_packet_envelope_encoder_tb.sv
